@@ rtl/vlds_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// vlds_pkg
// Shared types for the vector line DAC setup block.
// -----------------------------------------------------------------------------
package vlds_pkg;

    localparam int CoordW = 12;
    localparam int StyleW = 4;
    localparam int CfgW   = 8;
    localparam int IdxW   = 3;
    localparam int InW    = 56;
    localparam int OutW   = 72;

    typedef enum logic [IdxW-1:0] {
        REG_COEFF_X = 3'd0,
        REG_COEFF_Y = 3'd1,
        REG_LIMIT_X = 3'd2,
        REG_LIMIT_Y = 3'd3
    } vlds_reg_t;

    // configuration offsets
    typedef struct packed {
        logic signed [CfgW-1:0] coeff_x;
        logic signed [CfgW-1:0] coeff_y;
        logic signed [CfgW-1:0] limit_x;
        logic signed [CfgW-1:0] limit_y;
    } vlds_cfg_t;

    // classified segment, as passed from front to back
    typedef struct packed {
        logic [CoordW-1:0] pos_x;
        logic [CoordW-1:0] pos_y;
        logic [CoordW-1:0] mag_x;
        logic [CoordW-1:0] mag_y;
        logic              neg_x;
        logic              neg_y;
        logic              on_x;
        logic              falling;
        logic              point;
        logic              in_range;
        logic [StyleW-1:0] style;
    } vlds_item_t;

endpackage
`default_nettype wire

@@ rtl/vector_line_dac_setup_unit.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// vector_line_dac_setup_unit
// Turns line segments into DAC position, coefficient and limit words.
// -----------------------------------------------------------------------------
// Input stream s_axis_*: one segment per beat. Output stream m_axis_*: one
// DAC setup word set per beat, in input order.
// Configuration: cfg_we/cfg_index/cfg_data write the four 8-bit offsets;
// indexes 4..7 are ignored. Write only while the block is idle.
// Pipeline: one front register, the queue, one multiply stage, 16 square root
// stages (one root bit each), 11 restoring divide stages (one quotient bit
// each) and the output register.
// Throughput: one segment per cycle, sustained while m_axis_tready does not stall.
// Reset clears all valid state and sets the offsets to zero.
// A stall at m_axis_tready freezes the back pipeline; the two-entry queue
// and the front register keep s_axis_tready high for a few more beats.
// -----------------------------------------------------------------------------
module vector_line_dac_setup_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [vlds_pkg::IdxW-1:0]     cfg_index,
    input  wire logic [vlds_pkg::CfgW-1:0]     cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_x, start_y, end_x, end_y, style_code, zero pad
    input  wire logic [vlds_pkg::InW-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // position_x, position_y, coefficient_x, coefficient_y, limit_value,
    // limit_on_x, limit_falling, point_flag, in_range, style_out, zero pad
    output logic [vlds_pkg::OutW-1:0]          m_axis_tdata
);

    vlds_pkg::vlds_cfg_t  cfg_reg;
    vlds_pkg::vlds_item_t f_item, q_item;
    logic                 f_valid, f_ready, q_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (vlds_pkg::vlds_reg_t'(cfg_index))
                vlds_pkg::REG_COEFF_X: cfg_reg.coeff_x <= cfg_data;
                vlds_pkg::REG_COEFF_Y: cfg_reg.coeff_y <= cfg_data;
                vlds_pkg::REG_LIMIT_X: cfg_reg.limit_x <= cfg_data;
                vlds_pkg::REG_LIMIT_Y: cfg_reg.limit_y <= cfg_data;
                default: ;
            endcase
        end
    end

    vlds_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    vlds_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    vlds_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

@@ rtl/vlds_front.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// vlds_front
// Accepts segments, picks the drawing direction and classifies them.
// -----------------------------------------------------------------------------
module vlds_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [vlds_pkg::InW-1:0]  in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output vlds_pkg::vlds_item_t           out_item
);

    logic                 vld_reg;
    vlds_pkg::vlds_item_t item_reg;
    vlds_pkg::vlds_item_t item_next;

    logic signed [13:0] x0, y0, x1, y1;
    logic signed [13:0] sum_x, sum_y, mid_x, mid_y;
    logic signed [13:0] fpos_x, fpos_y, rpos_x, rpos_y, pos_x, pos_y;
    logic signed [13:0] dx, dy, ax, ay;
    logic               point, fwd_ok, swap, on_x;

    always_comb
    begin
        x0 = 14'(signed'(in_data[11:0]));
        y0 = 14'(signed'(in_data[23:12]));
        x1 = 14'(signed'(in_data[35:24]));
        y1 = 14'(signed'(in_data[47:36]));
        dx = x1 - x0;
        dy = y1 - y0;
        point = (dx == 14'sd0) && (dy == 14'sd0);
        sum_x = x0 + x1;
        sum_y = y0 + y1;
        // truncate toward zero
        mid_x = (sum_x + $signed({13'd0, sum_x[13]})) >>> 1;
        mid_y = (sum_y + $signed({13'd0, sum_y[13]})) >>> 1;
        fpos_x = 14'sd2048 - x0;
        fpos_y = 14'sd2048 - y0;
        rpos_x = 14'sd2048 - x1;
        rpos_y = 14'sd2048 - y1;
        fwd_ok = !fpos_x[13] && !fpos_x[12] && !fpos_y[13] && !fpos_y[12];
        swap = !point && !fwd_ok;
        if (point)
        begin
            pos_x = 14'sd2048 - mid_x;
            pos_y = 14'sd2048 - mid_y;
        end
        else if (swap)
        begin
            pos_x = rpos_x;
            pos_y = rpos_y;
            dx = -dx;
            dy = -dy;
        end
        else
        begin
            pos_x = fpos_x;
            pos_y = fpos_y;
        end
        ax = dx[13] ? -dx : dx;
        ay = dy[13] ? -dy : dy;
        on_x = ax > ay;

        item_next.pos_x    = pos_x[11:0];
        item_next.pos_y    = pos_y[11:0];
        item_next.mag_x    = ax[11:0];
        item_next.mag_y    = ay[11:0];
        item_next.neg_x    = dx[13];
        item_next.neg_y    = dy[13];
        item_next.on_x     = on_x && !point;
        item_next.falling  = !point && (on_x ? (dx > 14'sd0) : (dy > 14'sd0));
        item_next.point    = point;
        item_next.in_range = !pos_x[13] && !pos_x[12] && !pos_y[13] && !pos_y[12];
        item_next.style    = in_data[51:48];
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/vlds_queue.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// vlds_queue
// Two-entry queue between the front and the back.
// -----------------------------------------------------------------------------
module vlds_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire vlds_pkg::vlds_item_t in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output vlds_pkg::vlds_item_t      out_item
);

    vlds_pkg::vlds_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/vlds_back.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// vlds_back
// Length, coefficient and limit pipeline with output register.
// -----------------------------------------------------------------------------
module vlds_back
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire vlds_pkg::vlds_cfg_t       cfg,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire vlds_pkg::vlds_item_t      in_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [vlds_pkg::OutW-1:0]      out_data
);

    localparam int SqSt  = 16;
    localparam int DivSt = 11;
    localparam logic [13:0] Gain = 14'd14329;

    logic adv;

    // multiply stage
    logic                 a_vld_reg;
    vlds_pkg::vlds_item_t a_item_reg;
    logic [31:0]          a_n_reg;
    logic [25:0]          a_numx_reg, a_numy_reg;

    // square root stages
    logic                 s_vld_reg  [SqSt];
    vlds_pkg::vlds_item_t s_item_reg [SqSt];
    logic [31:0]          s_n_reg    [SqSt];
    logic [31:0]          s_root_reg [SqSt];
    logic [25:0]          s_numx_reg [SqSt];
    logic [25:0]          s_numy_reg [SqSt];
    logic [31:0]          s_n_next   [SqSt];
    logic [31:0]          s_root_next[SqSt];

    // divide stages
    logic                 d_vld_reg  [DivSt];
    vlds_pkg::vlds_item_t d_item_reg [DivSt];
    logic [15:0]          d_len_reg  [DivSt];
    logic [25:0]          d_remx_reg [DivSt];
    logic [25:0]          d_remy_reg [DivSt];
    logic [10:0]          d_qx_reg   [DivSt];
    logic [10:0]          d_qy_reg   [DivSt];
    logic [25:0]          d_remx_next[DivSt];
    logic [25:0]          d_remy_next[DivSt];
    logic [10:0]          d_qx_next  [DivSt];
    logic [10:0]          d_qy_next  [DivSt];

    logic                    o_vld_reg;
    logic [vlds_pkg::OutW-1:0] o_data_reg;
    logic [vlds_pkg::OutW-1:0] o_data_next;

    assign adv       = !o_vld_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = o_vld_reg;
    assign out_data  = o_data_reg;

    function automatic logic [11:0] sat12(input logic signed [14:0] v);
        if (v < 15'sd0)
        begin
            return 12'd0;
        end
        else if (v > 15'sd4095)
        begin
            return 12'd4095;
        end
        return v[11:0];
    endfunction

    always_comb
    begin
        logic [31:0] n_in, r_in, bitv;
        logic [25:0] rx_in, ry_in, trial;
        logic [10:0] qx_in, qy_in;
        logic [15:0] len;
        for (int k = 0; k < SqSt; k++)
        begin
            n_in = (k == 0) ? a_n_reg : s_n_reg[(k == 0) ? 0 : k - 1];
            r_in = (k == 0) ? 32'd0 : s_root_reg[(k == 0) ? 0 : k - 1];
            bitv = 32'd1 << (30 - 2 * k);
            if (n_in >= r_in + bitv)
            begin
                s_n_next[k]    = n_in - (r_in + bitv);
                s_root_next[k] = (r_in >> 1) + bitv;
            end
            else
            begin
                s_n_next[k]    = n_in;
                s_root_next[k] = r_in >> 1;
            end
        end
        for (int j = 0; j < DivSt; j++)
        begin
            if (j == 0)
            begin
                len   = s_root_reg[SqSt-1][15:0];
                rx_in = s_numx_reg[SqSt-1];
                ry_in = s_numy_reg[SqSt-1];
                qx_in = 11'd0;
                qy_in = 11'd0;
            end
            else
            begin
                len   = d_len_reg[j-1];
                rx_in = d_remx_reg[j-1];
                ry_in = d_remy_reg[j-1];
                qx_in = d_qx_reg[j-1];
                qy_in = d_qy_reg[j-1];
            end
            trial = {10'd0, len} << (DivSt - 1 - j);
            d_remx_next[j] = rx_in;
            d_remy_next[j] = ry_in;
            d_qx_next[j]   = qx_in;
            d_qy_next[j]   = qy_in;
            if (rx_in >= trial)
            begin
                d_remx_next[j] = rx_in - trial;
                d_qx_next[j][DivSt-1-j] = 1'b1;
            end
            if (ry_in >= trial)
            begin
                d_remy_next[j] = ry_in - trial;
                d_qy_next[j][DivSt-1-j] = 1'b1;
            end
        end
    end

    // finalize
    always_comb
    begin
        vlds_pkg::vlds_item_t it;
        logic signed [14:0] cx, cy, lim;
        logic [10:0]        h;
        logic [11:0]        cx_o, cy_o, lim_o;
        it = d_item_reg[DivSt-1];
        cx = it.neg_x ? 15'sd2048 - 15'(d_qx_reg[DivSt-1])
                      : 15'sd2048 + 15'(d_qx_reg[DivSt-1]);
        cy = it.neg_y ? 15'sd2048 - 15'(d_qy_reg[DivSt-1])
                      : 15'sd2048 + 15'(d_qy_reg[DivSt-1]);
        cx = cx + 15'(cfg.coeff_x);
        cy = cy + 15'(cfg.coeff_y);
        h  = it.on_x ? it.mag_x[11:1] : it.mag_y[11:1];
        if (it.falling)
        begin
            lim = (h > 11'd2000) ? 15'sd0 : 15'sd2048 - 15'(h);
        end
        else
        begin
            lim = (h > 11'd2000) ? 15'sd4095 : 15'sd2048 + 15'(h);
        end
        lim = lim + (it.on_x ? 15'(cfg.limit_x) : 15'(cfg.limit_y));
        cx_o  = it.point ? 12'd0 : sat12(cx);
        cy_o  = it.point ? 12'd0 : sat12(cy);
        lim_o = it.point ? 12'd0 : sat12(lim);
        o_data_next = {4'd0, it.style, it.in_range, it.point, it.falling, it.on_x,
                       lim_o, cy_o, cx_o, it.pos_y, it.pos_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            for (int k = 0; k < SqSt; k++)
            begin
                s_vld_reg[k] <= 1'b0;
            end
            for (int j = 0; j < DivSt; j++)
            begin
                d_vld_reg[j] <= 1'b0;
            end
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg    <= in_valid;
            s_vld_reg[0] <= a_vld_reg;
            for (int k = 1; k < SqSt; k++)
            begin
                s_vld_reg[k] <= s_vld_reg[k-1];
            end
            d_vld_reg[0] <= s_vld_reg[SqSt-1];
            for (int j = 1; j < DivSt; j++)
            begin
                d_vld_reg[j] <= d_vld_reg[j-1];
            end
            o_vld_reg <= d_vld_reg[DivSt-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= in_item;
            // 64 * (dx^2 + dy^2); the sum fits in 26 bits
            a_n_reg    <= {26'(in_item.mag_x) * 26'(in_item.mag_x)
                           + 26'(in_item.mag_y) * 26'(in_item.mag_y), 6'd0};
            a_numx_reg <= 26'(in_item.mag_x) * 26'(Gain);
            a_numy_reg <= 26'(in_item.mag_y) * 26'(Gain);

            s_item_reg[0] <= a_item_reg;
            s_numx_reg[0] <= a_numx_reg;
            s_numy_reg[0] <= a_numy_reg;
            for (int k = 1; k < SqSt; k++)
            begin
                s_item_reg[k] <= s_item_reg[k-1];
                s_numx_reg[k] <= s_numx_reg[k-1];
                s_numy_reg[k] <= s_numy_reg[k-1];
            end
            for (int k = 0; k < SqSt; k++)
            begin
                s_n_reg[k]    <= s_n_next[k];
                s_root_reg[k] <= s_root_next[k];
            end

            d_item_reg[0] <= s_item_reg[SqSt-1];
            d_len_reg[0]  <= s_root_reg[SqSt-1][15:0];
            for (int j = 1; j < DivSt; j++)
            begin
                d_item_reg[j] <= d_item_reg[j-1];
                d_len_reg[j]  <= d_len_reg[j-1];
            end
            for (int j = 0; j < DivSt; j++)
            begin
                d_remx_reg[j] <= d_remx_next[j];
                d_remy_reg[j] <= d_remy_next[j];
                d_qx_reg[j]   <= d_qx_next[j];
                d_qy_reg[j]   <= d_qy_next[j];
            end
            o_data_reg <= o_data_next;
        end
    end

endmodule
`default_nettype wire

@@ test/tb_vector_line_dac_setup_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_vector_line_dac_setup_unit
// Self-checking bench for the vector line DAC setup block.
// -----------------------------------------------------------------------------
// Segments go in on the slave stream and DAC word sets are checked beat by beat
// against a behavioral model of the setup math (root, divide, clamps, reversal).
// A directed table comes first, then random segments under several offset
// settings and three idling mixes, with one long output stall.
// -----------------------------------------------------------------------------
module tb_vector_line_dac_setup_unit;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 40;
    localparam int MaxReports    = 10;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [vlds_pkg::IdxW-1:0]     cfg_index;
    logic [vlds_pkg::CfgW-1:0]     cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [vlds_pkg::InW-1:0]      s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [vlds_pkg::OutW-1:0]     m_axis_tdata;

    vector_line_dac_setup_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // model copy of the offset registers
    logic signed [vlds_pkg::CfgW-1:0] ofs_cx, ofs_cy, ofs_lx, ofs_ly;

    logic [vlds_pkg::OutW-1:0] dac_words_q[$];   // expected word sets, oldest first
    bit                        fixed_has_q[$];   // per sent beat: typed expectation present
    logic [vlds_pkg::OutW-1:0] fixed_exp_q[$];

    int  send_idle_pct, recv_idle_pct;
    bit  hold_req;
    int  hold_cnt;
    int  errors, n_in, n_out, n_points, n_swapped, quiet_cycles;

    string fld_name [10] = '{"position_x", "position_y", "coefficient_x",
        "coefficient_y", "limit_value", "limit_on_x", "limit_falling",
        "point_flag", "in_range", "style_out"};
    int fld_lo [10] = '{0, 12, 24, 36, 48, 60, 61, 62, 63, 64};
    int fld_w  [10] = '{12, 12, 12, 12, 12, 1, 1, 1, 1, 4};

    function automatic int sat_dac(int v);
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    function automatic int int_sqrt(longint n);
        longint r = 0;
        for (int b = 20; b >= 0; b--)
            if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= n)
                r += 64'd1 << b;
        return int'(r);
    endfunction

    function automatic int dir_coeff(int d, int len);
        int q;
        q = ((d < 0 ? -d : d) * 14329) / len;
        return d < 0 ? 2048 - q : 2048 + q;
    endfunction

    function automatic logic [vlds_pkg::OutW-1:0] pack_words(int px, int py, int cx,
        int cy, int lim, bit on_x, bit fall, bit pt, bit inr, logic [3:0] st);
        logic [vlds_pkg::OutW-1:0] w;
        w = '0;
        w[11:0]  = px[11:0];
        w[23:12] = py[11:0];
        w[35:24] = cx[11:0];
        w[47:36] = cy[11:0];
        w[59:48] = lim[11:0];
        w[60] = on_x;
        w[61] = fall;
        w[62] = pt;
        w[63] = inr;
        w[67:64] = st;
        return w;
    endfunction

    function automatic logic [vlds_pkg::OutW-1:0] seg_setup(int x0, int y0, int x1,
        int y1, logic [3:0] st, output bit inr);
        int  dx, dy, big, px, py, cx, cy, lim, h, len;
        bit  on_x, fall, pt;
        dx = x1 - x0;
        dy = y1 - y0;
        on_x = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy);
        big = on_x ? dx : dy;
        fall = big > 0;
        pt = big == 0;
        cx = 0;
        cy = 0;
        lim = 0;
        if (pt) begin
            px = 2048 - (x0 + x1) / 2;
            py = 2048 - (y0 + y1) / 2;
            on_x = 0;
            fall = 0;
        end
        else begin
            len = int_sqrt(64 * (longint'(dx) * dx + longint'(dy) * dy));
            px = 2048 - x0;
            py = 2048 - y0;
            cx = sat_dac(dir_coeff(dx, len) + ofs_cx);
            cy = sat_dac(dir_coeff(dy, len) + ofs_cy);
            h = (big < 0 ? -big : big) / 2;
            if (fall)
                lim = h > 2000 ? 0 : 2048 - h;
            else
                lim = h > 2000 ? 4095 : 2048 + h;
            lim = sat_dac(lim + (on_x ? int'(ofs_lx) : int'(ofs_ly)));
        end
        inr = px >= 0 && px < 4096 && py >= 0 && py < 4096;
        return pack_words(px, py, cx, cy, lim, on_x, fall, pt, inr, st);
    endfunction

    function automatic logic [vlds_pkg::OutW-1:0] predict_dac(
        logic [vlds_pkg::InW-1:0] d);
        int x0, y0, x1, y1;
        bit ok;
        logic [vlds_pkg::OutW-1:0] w;
        x0 = int'($signed(d[11:0]));
        y0 = int'($signed(d[23:12]));
        x1 = int'($signed(d[35:24]));
        y1 = int'($signed(d[47:36]));
        w = seg_setup(x0, y0, x1, y1, d[51:48], ok);
        if (!ok)
            w = seg_setup(x1, y1, x0, y0, d[51:48], ok);
        return w;
    endfunction

    // handshake monitor, checker and watchdog
    always @(posedge clk) begin
        logic [vlds_pkg::OutW-1:0] exp_w;
        bit bad;
        bit moved;
        if (rst_n) begin
            moved = 0;
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1;
                n_in <= n_in + 1;
                exp_w = predict_dac(s_axis_tdata);
                if (fixed_has_q.pop_front())
                    exp_w = fixed_exp_q.pop_front();
                else
                    void'(fixed_exp_q.pop_front());
                if (exp_w[62]) n_points <= n_points + 1;
                if (exp_w[11:0] != 12'(2048 - int'($signed(s_axis_tdata[11:0])))
                    && !exp_w[62])
                    n_swapped <= n_swapped + 1;
                dac_words_q.push_back(exp_w);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1;
                n_out <= n_out + 1;
                if (dac_words_q.size() == 0) begin
                    errors++;
                    if (errors <= MaxReports)
                        $display("ERROR: unexpected result beat %h", m_axis_tdata);
                end
                else begin
                    exp_w = dac_words_q.pop_front();
                    bad = 0;
                    for (int f = 0; f < 10; f++)
                        if (((m_axis_tdata >> fld_lo[f]) & ((72'd1 << fld_w[f]) - 1)) !=
                            ((exp_w >> fld_lo[f]) & ((72'd1 << fld_w[f]) - 1))) begin
                            bad = 1;
                            if (errors < MaxReports)
                                $display("ERROR: %s expected %0h got %0h", fld_name[f],
                                    (exp_w >> fld_lo[f]) & ((72'd1 << fld_w[f]) - 1),
                                    (m_axis_tdata >> fld_lo[f]) &
                                    ((72'd1 << fld_w[f]) - 1));
                        end
                    if (bad)
                        errors++;
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_req) begin
            hold_cnt = 300;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end

    task automatic send_seg(logic [vlds_pkg::InW-1:0] d, bit has_fixed,
        logic [vlds_pkg::OutW-1:0] fixed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        fixed_has_q.push_back(has_fixed);
        fixed_exp_q.push_back(fixed);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    function automatic logic [vlds_pkg::InW-1:0] seg_word(int x0, int y0, int x1,
        int y1, logic [3:0] st);
        logic [vlds_pkg::InW-1:0] d;
        d = '0;
        d[11:0]  = x0[11:0];
        d[23:12] = y0[11:0];
        d[35:24] = x1[11:0];
        d[47:36] = y1[11:0];
        d[51:48] = st;
        return d;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (dac_words_q.size() != 0 || fixed_has_q.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_ofs(vlds_pkg::vlds_reg_t idx, logic [vlds_pkg::CfgW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            vlds_pkg::REG_COEFF_X: ofs_cx = val;
            vlds_pkg::REG_COEFF_Y: ofs_cy = val;
            vlds_pkg::REG_LIMIT_X: ofs_lx = val;
            vlds_pkg::REG_LIMIT_Y: ofs_ly = val;
            default: ;
        endcase
    endtask

    task automatic set_offsets(int cx, int cy, int lx, int ly);
        write_ofs(vlds_pkg::REG_COEFF_X, cx[7:0]);
        write_ofs(vlds_pkg::REG_COEFF_Y, cy[7:0]);
        write_ofs(vlds_pkg::REG_LIMIT_X, lx[7:0]);
        write_ofs(vlds_pkg::REG_LIMIT_Y, ly[7:0]);
    endtask

    task automatic random_segs(int count);
        int x0, y0, x1, y1, kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(9);
            x0 = $urandom_range(4095) - 2048;
            y0 = $urandom_range(4095) - 2048;
            x1 = $urandom_range(4095) - 2048;
            y1 = $urandom_range(4095) - 2048;
            if (kind == 0) begin            // point
                x1 = x0;
                y1 = y0;
            end
            else if (kind == 1)             // start off the DAC range
                x0 = -2048;
            else if (kind == 2)
                y0 = -2048;
            else if (kind < 6) begin        // short segment
                x1 = x0 + $urandom_range(15) - 8;
                y1 = y0 + $urandom_range(15) - 8;
            end
            send_seg(seg_word(x0, y0, x1, y1, 4'($urandom)), 0, '0);
        end
    endtask

    typedef struct {
        int x0, y0, x1, y1;
        logic [3:0] st;
        bit has_fixed;
        logic [vlds_pkg::OutW-1:0] fixed;
    } seg_row_t;

    seg_row_t dir_rows [$];

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_req = 0;
        hold_cnt = 0;
        errors = 0;
        n_in = 0;
        n_out = 0;
        n_points = 0;
        n_swapped = 0;
        quiet_cycles = 0;
        {ofs_cx, ofs_cy, ofs_lx, ofs_ly} = '0;
        send_idle_pct = 27;
        recv_idle_pct = 59;

        // origin point, a plain rightward line and an off-range corner point, worked out by hand
        dir_rows = '{
            '{0, 0, 0, 0, 4'd0, 1, pack_words(2048, 2048, 0, 0, 0, 0, 0, 1, 1, 4'd0)},
            '{0, 0, 100, 0, 4'd5, 1,
                pack_words(2048, 2048, 3839, 2048, 1998, 1, 1, 0, 1, 4'd5)},
            '{-2048, -2048, -2048, -2048, 4'd15, 1,
                pack_words(4096, 4096, 0, 0, 0, 0, 0, 1, 0, 4'd15)},
            '{2047, 2047, 2047, 2047, 4'd9, 0, '0},
            '{-2048, 0, 2047, 0, 4'd1, 0, '0},
            '{2047, 0, -2048, 0, 4'd2, 0, '0},
            '{0, -2048, 0, 2047, 4'd3, 0, '0},
            '{0, 2047, 0, -2048, 4'd4, 0, '0},
            '{-2048, -2048, 2047, 2047, 4'd6, 0, '0},
            '{-2048, -2048, -2048, 2047, 4'd7, 0, '0},
            '{2047, -2048, -2048, 2047, 4'd8, 0, '0},
            '{-2048, 5, -1000, 5, 4'd10, 0, '0},
            '{0, 0, 1, 1, 4'd11, 0, '0},
            '{0, 0, -1, 0, 4'd12, 0, '0},
            '{0, 0, 0, -1, 4'd13, 0, '0},
            '{-3, 7, 4, 7, 4'd14, 0, '0},
            '{100, 200, -100, -200, 4'd5, 0, '0},
            '{0, 0, 3, -4, 4'd10, 0, '0},
            '{-2048, 100, 2047, 100, 4'd0, 0, '0},
            '{-1, -1, 2, 2, 4'd3, 0, '0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_seg(seg_word(dir_rows[i].x0, dir_rows[i].y0, dir_rows[i].x1,
                dir_rows[i].y1, dir_rows[i].st), dir_rows[i].has_fixed,
                dir_rows[i].fixed);
        drain();

        set_offsets(127, -128, 127, -128);
        write_ofs(vlds_pkg::vlds_reg_t'(3'd5), 8'hFF);   // out-of-map index, ignored
        foreach (dir_rows[i])
            send_seg(seg_word(dir_rows[i].x0, dir_rows[i].y0, dir_rows[i].x1,
                dir_rows[i].y1, dir_rows[i].st), 0, '0);
        random_segs(200);
        drain();

        send_idle_pct = 59;
        recv_idle_pct = 27;
        set_offsets(-128, 127, -128, 127);
        random_segs(250);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_offsets($urandom_range(255) - 128, $urandom_range(255) - 128,
            $urandom_range(255) - 128, $urandom_range(255) - 128);
        hold_req = 1;
        random_segs(250);
        drain();

        $display("Ran %0d segments, %0d results, %0d points, %0d reversed setups,",
            n_in, n_out, n_points, n_swapped);
        $display("across four offset settings and three stall mixes.");
        if (errors == 0 && dac_words_q.size() == 0)
            $display("vector_line_dac_setup_unit test passed");
        else
            $display("vector_line_dac_setup_unit test failed");
        $finish;
    end

    initial begin
        wait (quiet_cycles >= WatchdogLimit);
        $display("ERROR: no beat moved for %0d cycles", WatchdogLimit);
        $display("vector_line_dac_setup_unit test failed");
        $finish;
    end

endmodule
